@@ hw/rtl/wdd_pkg.sv @@
// wdd_pkg: shared constants, codes and control/status types of the drawdown detector
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package wdd_pkg;

   // history depth per side and derived counter width
   localparam int WINDOW_DEPTH = 64;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

   // field widths
   localparam int ACT_W   = 2;
   localparam int PRICE_W = 16;
   localparam int TIME_W  = 32;
   localparam int FRAC_W  = 17;
   localparam int WIN_W   = 16;
   localparam int SIDE_W  = 2;

   // window span in ms: 16-bit seconds times 1000 fits in 26 bits
   localparam int MS_PER_SEC = 1000;
   localparam int SPAN_W     = 26;

   // serial divider: one quotient bit per step below the integer bit
   localparam int DIV_STEPS = PRICE_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // csr port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [FRAC_W-1:0] THR_RESET = 17'd6554;
   localparam logic [WIN_W-1:0]  WIN_RESET = 16'd60;

   // action codes
   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DETECT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   // price side of an add
   localparam logic PRICE_UP   = 1'b0;
   localparam logic PRICE_DOWN = 1'b1;

   // reported side codes
   localparam logic [SIDE_W-1:0] SIDE_NONE = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_UP   = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_DOWN = 2'd2;

   // register indexes
   localparam logic REG_THR = 1'b0;
   localparam logic REG_WIN = 1'b1;

   typedef struct packed {
      logic add;
      logic rotate;
      logic clear;
      logic scan;
      logic first;
   } chain_ctl_type;

   typedef struct packed {
      logic               ok;
      logic [PRICE_W-1:0] peak;
      logic [PRICE_W-1:0] latest;
   } chain_stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/wdd_if.sv @@
// wdd_req_if / wdd_rsp_if: valid/ready channels of the drawdown detector
// depends on wdd_pkg for field widths
`default_nettype none

interface wdd_req_if;
   logic                         valid;
   logic                         ready;
   logic [wdd_pkg::ACT_W-1:0]    action;
   logic                         price_side;
   logic [wdd_pkg::PRICE_W-1:0]  price;
   logic [wdd_pkg::TIME_W-1:0]   now_ms;

   modport source (output valid, action, price_side, price, now_ms, input ready);
   modport sink   (input valid, action, price_side, price, now_ms, output ready);
endinterface

interface wdd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         detected;
   logic [wdd_pkg::SIDE_W-1:0]   drop_side;
   logic [wdd_pkg::FRAC_W-1:0]   drop_fraction;
   logic [wdd_pkg::PRICE_W-1:0]  peak_price;
   logic [wdd_pkg::PRICE_W-1:0]  last_price;

   modport source (output valid, detected, drop_side, drop_fraction, peak_price, last_price,
                   input ready);
   modport sink   (input valid, detected, drop_side, drop_fraction, peak_price, last_price,
                   output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wdd_cell.sv @@
// wdd_cell: one history slot holding a price and its time stamp
// depends on wdd_pkg; loads from the newer-side neighbor on add, older-side on rotate
`default_nettype none

module wdd_cell (
   input  logic                        clock,
   input  wdd_pkg::chain_ctl_type      ctl,
   input  logic [wdd_pkg::PRICE_W-1:0] shift_price,
   input  logic [wdd_pkg::TIME_W-1:0]  shift_stamp,
   input  logic [wdd_pkg::PRICE_W-1:0] rot_price,
   input  logic [wdd_pkg::TIME_W-1:0]  rot_stamp,
   output logic [wdd_pkg::PRICE_W-1:0] price,
   output logic [wdd_pkg::TIME_W-1:0]  stamp
);

   logic [wdd_pkg::PRICE_W-1:0] price_ff, price_in;
   logic [wdd_pkg::TIME_W-1:0]  stamp_ff, stamp_in;

   always_comb begin
      price_in = price_ff;
      stamp_in = stamp_ff;
      if (ctl.add) begin
         price_in = shift_price;
         stamp_in = shift_stamp;
      end else if (ctl.rotate) begin
         price_in = rot_price;
         stamp_in = rot_stamp;
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      stamp_ff <= stamp_in;
   end

   assign price = price_ff;
   assign stamp = stamp_ff;

endmodule

`default_nettype wire

@@ hw/rtl/wdd_chain.sv @@
// wdd_chain: one side's history as a ring of wdd_cell, newest entry in slot 0,
// with the fill count and the newest-to-oldest peak scan; depends on wdd_pkg, wdd_cell
`default_nettype none

module wdd_chain (
   input  logic                        clock,
   input  logic                        reset,
   input  wdd_pkg::chain_ctl_type      ctl,
   input  logic [wdd_pkg::PRICE_W-1:0] new_price,
   input  logic [wdd_pkg::TIME_W-1:0]  new_stamp,
   input  logic [wdd_pkg::TIME_W-1:0]  cutoff,
   input  logic [wdd_pkg::CNT_W-1:0]   step,
   output wdd_pkg::chain_stat_type     stat
);

   logic [wdd_pkg::PRICE_W-1:0] price_w [wdd_pkg::WINDOW_DEPTH];
   logic [wdd_pkg::TIME_W-1:0]  stamp_w [wdd_pkg::WINDOW_DEPTH];

   logic [wdd_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [wdd_pkg::PRICE_W-1:0] best_ff, best_in, base_best;
   logic [wdd_pkg::PRICE_W-1:0] latest_ff, latest_in;
   logic                        stop_ff, stop_in, base_stop;
   logic                        live;

   for (genvar k = 0; k < wdd_pkg::WINDOW_DEPTH; k++) begin : g_node
      localparam int NEXT = (k + 1) % wdd_pkg::WINDOW_DEPTH;
      logic [wdd_pkg::PRICE_W-1:0] src_price;
      logic [wdd_pkg::TIME_W-1:0]  src_stamp;

      if (k == 0) begin : g_head
         assign src_price = new_price;
         assign src_stamp = new_stamp;
      end else begin : g_body
         assign src_price = price_w[k-1];
         assign src_stamp = stamp_w[k-1];
      end

      wdd_cell u_node (
         .clock       (clock),
         .ctl         (ctl),
         .shift_price (src_price),
         .shift_stamp (src_stamp),
         .rot_price   (price_w[NEXT]),
         .rot_stamp   (stamp_w[NEXT]),
         .price       (price_w[k]),
         .stamp       (stamp_w[k])
      );
   end

   // slot 0 holds entry number step of the scan, newest first
   always_comb begin
      base_best = ctl.first ? '0 : best_ff;
      base_stop = ctl.first ? 1'b0 : stop_ff;
      live      = (step < count_ff) && !base_stop;
      best_in   = best_ff;
      stop_in   = stop_ff;
      latest_in = latest_ff;
      if (ctl.scan) begin
         best_in = base_best;
         stop_in = base_stop;
         if (ctl.first) begin
            latest_in = price_w[0];
         end
         if (live) begin
            if (stamp_w[0] < cutoff) begin
               stop_in = 1'b1;
            end else if (price_w[0] > base_best) begin
               best_in = price_w[0];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.add && (count_ff != wdd_pkg::CNT_W'(wdd_pkg::WINDOW_DEPTH))) begin
         count_in = count_ff + wdd_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         stop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         stop_ff  <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff   <= best_in;
      latest_ff <= latest_in;
   end

   assign stat.ok     = (count_ff != '0) && (best_ff != '0) && (latest_ff < best_ff);
   assign stat.peak   = best_ff;
   assign stat.latest = latest_ff;

endmodule

`default_nettype wire

@@ hw/rtl/wdd_divider.sv @@
// wdd_divider: restoring divider giving floor(diff * 65536 / peak), one bit per cycle
// depends on wdd_pkg; requires diff <= peak and peak != 0
`default_nettype none

module wdd_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wdd_pkg::PRICE_W-1:0] diff,
   input  logic [wdd_pkg::PRICE_W-1:0] peak,
   output logic                        done,
   output logic [wdd_pkg::FRAC_W-1:0]  quotient
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [wdd_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [wdd_pkg::PRICE_W:0]   rem_ff, rem_in, shifted;
   logic [wdd_pkg::FRAC_W-1:0]  quo_ff, quo_in;
   logic [wdd_pkg::PRICE_W-1:0] den_ff, den_in;
   logic                        ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff[wdd_pkg::PRICE_W-1:0], 1'b0};
      ge      = 1'b0;
      if (start) begin
         // integer bit: set only when the latest price is zero
         ge      = (diff >= peak);
         rem_in  = ge ? {1'b0, diff - peak} : {1'b0, diff};
         quo_in  = {{(wdd_pkg::FRAC_W-1){1'b0}}, ge};
         den_in  = peak;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         ge      = (shifted >= {1'b0, den_ff});
         rem_in  = ge ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in  = {quo_ff[wdd_pkg::FRAC_W-2:0], ge};
         step_in = step_ff + wdd_pkg::STEP_W'(1);
         if (step_ff == wdd_pkg::STEP_W'(wdd_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/windowed_drawdown_detector.sv @@
// windowed_drawdown_detector: top level with control sequencer, csr registers, result register
// depends on wdd_pkg, wdd_if, wdd_chain, wdd_divider
`default_nettype none

// Keeps two price histories of 64 entries each (up and down side), each a ring of cells
// with the newest entry in slot 0. An add word shifts the new price and time stamp into
// its side and drops the oldest entry when the side is full; a clear word empties both
// sides. A detect word returns one result word: first the time cutoff is formed (now_ms
// minus 1000 times the window length, floored at zero), then both rings make one full
// turn past slot 0 so the peak within the window is found newest to oldest, then for each
// side with a real drop the shared 16-step serial divider runs once, and a last step picks
// the side and loads the result register once that register is empty or being read. The
// next word is taken while a finished result still waits in the output register. Registers:
// drop_threshold at byte 0 (Q1.16, reset 6554), the window length in seconds at byte 4
// (reset 60); write them only while the block is idle.

module windowed_drawdown_detector (
   input  logic                       clock,
   input  logic                       reset,
   wdd_req_if.sink                    req,
   wdd_rsp_if.source                  rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [wdd_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [wdd_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [wdd_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CUT   = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_UGO   = 3'd3;
   localparam logic [2:0] ST_UWAIT = 3'd4;
   localparam logic [2:0] ST_DGO   = 3'd5;
   localparam logic [2:0] ST_DWAIT = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;

   // csr registers
   logic [wdd_pkg::FRAC_W-1:0] thr_ff, thr_in;
   logic [wdd_pkg::WIN_W-1:0]  win_ff, win_in;
   logic [wdd_pkg::SPAN_W-1:0] span_ff;
   logic                       csr_wr;

   // detect working registers
   logic [wdd_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [wdd_pkg::TIME_W-1:0]  cutoff_ff, cutoff_in;
   logic [wdd_pkg::TIME_W-1:0]  span_ext;
   logic [wdd_pkg::CNT_W-1:0]   step_ff, step_in;
   logic [wdd_pkg::FRAC_W-1:0]  ud_ff, ud_in, dd_ff, dd_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        det_ff;
   logic [wdd_pkg::SIDE_W-1:0]  side_ff;
   logic [wdd_pkg::FRAC_W-1:0]  frac_ff;
   logic [wdd_pkg::PRICE_W-1:0] from_ff, to_ff;

   // side selection
   logic [wdd_pkg::SIDE_W-1:0]  sel_side;
   logic [wdd_pkg::FRAC_W-1:0]  sel_frac;
   logic [wdd_pkg::PRICE_W-1:0] sel_from, sel_to;
   logic                        out_load;

   // chains and divider
   wdd_pkg::chain_ctl_type      up_ctl, dn_ctl;
   wdd_pkg::chain_stat_type     up_stat, dn_stat;
   logic                        req_fire;
   logic                        div_start, div_done;
   logic [wdd_pkg::PRICE_W-1:0] div_diff, div_peak;
   logic [wdd_pkg::FRAC_W-1:0]  div_q;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;

   // ---------------- csr port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      thr_in = thr_ff;
      win_in = win_ff;
      if (csr_wr) begin
         unique case (csr_paddr[wdd_pkg::CSR_AW-1])
            wdd_pkg::REG_THR: begin
               thr_in = csr_pwdata[wdd_pkg::FRAC_W-1:0];
            end
            wdd_pkg::REG_WIN: begin
               win_in = csr_pwdata[wdd_pkg::WIN_W-1:0];
            end
            default: begin
               thr_in = thr_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[wdd_pkg::CSR_AW-1])
         wdd_pkg::REG_THR: begin
            csr_prdata = wdd_pkg::CSR_DW'(thr_ff);
         end
         wdd_pkg::REG_WIN: begin
            csr_prdata = wdd_pkg::CSR_DW'(win_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= wdd_pkg::THR_RESET;
         win_ff <= wdd_pkg::WIN_RESET;
      end else begin
         thr_ff <= thr_in;
         win_ff <= win_in;
      end
   end

   // window span in ms, refreshed every cycle from the register
   always_ff @(posedge clock) begin
      span_ff <= wdd_pkg::SPAN_W'(win_ff) * wdd_pkg::SPAN_W'(wdd_pkg::MS_PER_SEC);
   end

   // ---------------- history chains ----------------
   always_comb begin
      up_ctl        = '0;
      up_ctl.add    = req_fire && (req.action == wdd_pkg::ACT_ADD)
                      && (req.price_side == wdd_pkg::PRICE_UP);
      up_ctl.clear  = req_fire && (req.action == wdd_pkg::ACT_CLEAR);
      up_ctl.rotate = (state_ff == ST_SCAN);
      up_ctl.scan   = (state_ff == ST_SCAN);
      up_ctl.first  = (step_ff == '0);
      dn_ctl        = up_ctl;
      dn_ctl.add    = req_fire && (req.action == wdd_pkg::ACT_ADD)
                      && (req.price_side == wdd_pkg::PRICE_DOWN);
   end

   wdd_chain u_up (
      .clock     (clock),
      .reset     (reset),
      .ctl       (up_ctl),
      .new_price (req.price),
      .new_stamp (req.now_ms),
      .cutoff    (cutoff_ff),
      .step      (step_ff),
      .stat      (up_stat)
   );

   wdd_chain u_dn (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dn_ctl),
      .new_price (req.price),
      .new_stamp (req.now_ms),
      .cutoff    (cutoff_ff),
      .step      (step_ff),
      .stat      (dn_stat)
   );

   // ---------------- shared divider ----------------
   always_comb begin
      if (state_ff == ST_DGO) begin
         div_peak  = dn_stat.peak;
         div_diff  = dn_stat.peak - dn_stat.latest;
         div_start = dn_stat.ok;
      end else begin
         div_peak  = up_stat.peak;
         div_diff  = up_stat.peak - up_stat.latest;
         div_start = (state_ff == ST_UGO) && up_stat.ok;
      end
   end

   wdd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .diff     (div_diff),
      .peak     (div_peak),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- side pick, ties go up ----------------
   always_comb begin
      sel_side = wdd_pkg::SIDE_NONE;
      sel_frac = '0;
      sel_from = '0;
      sel_to   = '0;
      // a real drop always gives a nonzero quotient
      if (ud_ff != '0) begin
         sel_side = wdd_pkg::SIDE_UP;
         sel_frac = ud_ff;
         sel_from = up_stat.peak;
         sel_to   = up_stat.latest;
      end
      if (dd_ff > sel_frac) begin
         sel_side = wdd_pkg::SIDE_DOWN;
         sel_frac = dd_ff;
         sel_from = dn_stat.peak;
         sel_to   = dn_stat.latest;
      end
   end

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign span_ext = wdd_pkg::TIME_W'(span_ff);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      now_in    = now_ff;
      cutoff_in = cutoff_ff;
      step_in   = step_ff;
      ud_in     = ud_ff;
      dd_in     = dd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_fire && (req.action == wdd_pkg::ACT_DETECT)) begin
               now_in   = req.now_ms;
               state_in = ST_CUT;
            end
         end
         ST_CUT: begin
            // cutoff floors at zero
            cutoff_in = (now_ff > span_ext) ? (now_ff - span_ext) : '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            step_in = step_ff + wdd_pkg::CNT_W'(1);
            if (step_ff == wdd_pkg::CNT_W'(wdd_pkg::WINDOW_DEPTH - 1)) begin
               state_in = ST_UGO;
            end
         end
         ST_UGO: begin
            ud_in    = '0;
            state_in = up_stat.ok ? ST_UWAIT : ST_DGO;
         end
         ST_UWAIT: begin
            if (div_done) begin
               ud_in    = div_q;
               state_in = ST_DGO;
            end
         end
         ST_DGO: begin
            dd_in    = '0;
            state_in = dn_stat.ok ? ST_DWAIT : ST_DONE;
         end
         ST_DWAIT: begin
            if (div_done) begin
               dd_in    = div_q;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      cutoff_ff <= cutoff_in;
      ud_ff     <= ud_in;
      dd_ff     <= dd_in;
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         det_ff  <= (sel_frac >= thr_ff);
         side_ff <= sel_side;
         frac_ff <= sel_frac;
         from_ff <= sel_from;
         to_ff   <= sel_to;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.detected      = det_ff;
   assign rsp.drop_side     = side_ff;
   assign rsp.drop_fraction = frac_ff;
   assign rsp.peak_price    = from_ff;
   assign rsp.last_price    = to_ff;

endmodule

`default_nettype wire

@@ hw/rtl/wdd_checker.sv @@
// wdd_checker: port-level assertions on the result channel of the drawdown detector
// depends on wdd_pkg; bound to windowed_drawdown_detector at the end of this file
`default_nettype none

module wdd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        detected,
   input logic [wdd_pkg::SIDE_W-1:0]  drop_side,
   input logic [wdd_pkg::FRAC_W-1:0]  drop_fraction,
   input logic [wdd_pkg::PRICE_W-1:0] peak_price,
   input logic [wdd_pkg::PRICE_W-1:0] last_price
);

   // stalled word stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn while stalled");

   a_word_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable({detected, drop_side, drop_fraction, peak_price, last_price}))
      else $error("result word changed while stalled");

   // no side chosen means a zero fraction and zero prices in the report
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (drop_side == wdd_pkg::SIDE_NONE) |->
         (drop_fraction == '0) && (peak_price == '0) && (last_price == '0))
      else $error("no side chosen but report fields nonzero");

   // a chosen side is a real drop below its peak
   a_real_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (drop_side != wdd_pkg::SIDE_NONE) |->
         (last_price < peak_price) && (drop_fraction != '0))
      else $error("chosen side has no real drop");

endmodule

bind windowed_drawdown_detector wdd_checker u_wdd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .detected      (rsp.detected),
   .drop_side     (rsp.drop_side),
   .drop_fraction (rsp.drop_fraction),
   .peak_price    (rsp.peak_price),
   .last_price    (rsp.last_price)
);

`default_nettype wire
